@@ rtl/g2ld_pkg.sv @@
`default_nettype none

package g2ld_pkg;

    localparam int BASE_YEAR     = 1921;
    localparam int TABLE_YEARS   = 100;
    localparam int ROM_SIZE      = 100;
    localparam int WALK_YEARS    = (TABLE_YEARS < ROM_SIZE) ? TABLE_YEARS : ROM_SIZE;
    localparam int IDX_W         = (WALK_YEARS > 1) ? $clog2(WALK_YEARS) : 1;
    localparam int ROM_IDX_W     = $clog2(ROM_SIZE);
    localparam int START_OFFSET  = 38;
    localparam int DAYS_PER_YEAR = 365;
    localparam int COUNT_W       = 20;
    localparam int CALC_W        = 22;
    localparam int ENTRY_W       = 20;
    localparam int LONG_MIN      = 4095;
    localparam int SHORT_MONTH   = 29;
    localparam int LAST_BIT_LONG = 12;
    localparam int LAST_BIT_STD  = 11;

    // Bits 11..0 (or 12..0) flag 30-day months, bits 19..16 name the month
    // that the leap month follows.
    localparam logic [ENTRY_W-1:0] LUNAR_ROM [ROM_SIZE] = '{
        20'd2635,   20'd333387, 20'd1701,   20'd1748,   20'd267701,
        20'd694,    20'd2391,   20'd133423, 20'd1175,   20'd396438,
        20'd3402,   20'd3749,   20'd331177, 20'd1453,   20'd694,
        20'd201326, 20'd2350,   20'd465197, 20'd3221,   20'd3402,
        20'd400202, 20'd2901,   20'd1386,   20'd267611, 20'd605,
        20'd2349,   20'd137515, 20'd2709,   20'd464533, 20'd1738,
        20'd2901,   20'd330421, 20'd1242,   20'd2651,   20'd199255,
        20'd1323,   20'd529706, 20'd3733,   20'd1706,   20'd398762,
        20'd2741,   20'd1206,   20'd267438, 20'd2647,   20'd1318,
        20'd204070, 20'd3477,   20'd461653, 20'd1386,   20'd2413,
        20'd330077, 20'd1197,   20'd2637,   20'd268877, 20'd3365,
        20'd531109, 20'd2900,   20'd2922,   20'd398042, 20'd2395,
        20'd1179,   20'd267415, 20'd2635,   20'd661067, 20'd1701,
        20'd1748,   20'd398772, 20'd2742,   20'd2391,   20'd330031,
        20'd1175,   20'd1611,   20'd200010, 20'd3749,   20'd527717,
        20'd1452,   20'd2742,   20'd332397, 20'd2350,   20'd3222,
        20'd268949, 20'd3402,   20'd3493,   20'd133973, 20'd1386,
        20'd464219, 20'd605,    20'd2349,   20'd334123, 20'd2709,
        20'd2890,   20'd267946, 20'd2773,   20'd592565, 20'd1210,
        20'd2651,   20'd395863, 20'd1323,   20'd2707,   20'd265877
    };

    localparam logic [8:0] MONTH_OFFSET [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             found;
        logic [IDX_W-1:0] year_idx;
        logic [3:0]       month;
        logic [4:0]       day;
        logic             leap;
    } walk_status_t;

    function automatic logic [ENTRY_W-1:0] rom_entry(input logic [ROM_IDX_W-1:0] idx);
        logic [ENTRY_W-1:0] value;
        value = '0;
        if (int'(idx) < ROM_SIZE)
        begin
            value = LUNAR_ROM[idx];
        end
        return value;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] value;
        logic [3:0] pos;
        value = '0;
        pos   = month - 4'd1;
        if (month >= 4'd1 && month <= 4'd12)
        begin
            value = MONTH_OFFSET[pos];
        end
        return value;
    endfunction

endpackage

`default_nettype wire

@@ rtl/gregorian_to_lunar_date.sv @@
// Steps: the request is registered, the day count is computed and checked, then the
// month walk counts off lunar months from 1921-02-08 through at most the table's hundred
// years, and the result is registered. Requests: one at a time; the month walk, one
// subtraction per cycle, limits the rate. A new request is taken while the last result waits.
// Reset (rst_n, asynchronous, active low) empties the block and the output.
`default_nettype none

module gregorian_to_lunar_date
    import g2ld_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // gregorian_year[11:0], gregorian_month[15:12], gregorian_day[20:16], zero fill
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // lunar_year[10:0], lunar_month[14:11], lunar_day[19:15], leap_month[20], zero fill
    output logic [23:0]      m_axis_tdata,
    // date_ok[0]
    output logic             m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_CHECK,
        S_WALK,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [11:0]         year_reg, year_next;
    logic [3:0]          month_reg, month_next;
    logic [4:0]          day_reg, day_next;
    logic [CALC_W-1:0]   count_reg, count_next;
    logic                bad_reg, bad_next;
    logic                ok_reg, ok_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_ok_reg, out_ok_next;
    logic [23:0]         out_data_reg, out_data_next;

    logic [11:0]         yoff;
    logic [CALC_W-1:0]   year_days;
    logic [CALC_W-1:0]   count_calc;
    logic                leap_add;
    logic                walk_start;
    logic                out_free;
    logic [10:0]         lunar_year;
    walk_status_t        walk_status;

    g2ld_month_walk u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (walk_start),
        .start_count (count_reg[COUNT_W-1:0]),
        .status      (walk_status)
    );

    always_comb
    begin
        yoff       = year_reg - 12'(BASE_YEAR);
        year_days  = CALC_W'(yoff) * CALC_W'(DAYS_PER_YEAR);
        leap_add   = (year_reg[1:0] == 2'b00) && (month_reg > 4'd2);
        // From 1921 on, dates before 1921-02-07 wrap below zero; bit 21 flags it.
        count_calc = year_days + CALC_W'(yoff[11:2]) + CALC_W'(day_reg)
                   + CALC_W'(days_before_month(month_reg)) + CALC_W'(leap_add)
                   - CALC_W'(START_OFFSET);
        walk_start = (state_reg == S_CHECK) && !bad_reg
                   && !count_reg[CALC_W-1] && (count_reg != '0);
        out_free   = !out_valid_reg || m_axis_tready;
        lunar_year = 11'(BASE_YEAR) + 11'(walk_status.year_idx);
    end

    always_comb
    begin
        state_next     = state_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        count_next     = count_reg;
        bad_next       = bad_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    year_next  = s_axis_tdata[11:0];
                    month_next = s_axis_tdata[15:12];
                    day_next   = s_axis_tdata[20:16];
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                count_next = count_calc;
                bad_next   = (year_reg < 12'(BASE_YEAR)) || (month_reg == 4'd0)
                           || (month_reg > 4'd12);
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (walk_start)
                begin
                    state_next = S_WALK;
                end
                else
                begin
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_WALK:
            begin
                if (walk_status.done)
                begin
                    ok_next    = walk_status.found;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_data_next  = ok_reg ? {3'b000, walk_status.leap, walk_status.day,
                                               walk_status.month, lunar_year}
                                            : 24'd0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            count_reg     <= '0;
            bad_reg       <= 1'b0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            count_reg     <= count_next;
            bad_reg       <= bad_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
            out_ok_reg    <= out_ok_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_ok_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 24'd0))
        else $error("invalid result carries nonzero fields");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed before it was taken");

    a_walk_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_WALK) |-> !walk_status.busy)
        else $error("month walk busy outside the walk state");

endmodule

`default_nettype wire

@@ rtl/g2ld_month_walk.sv @@
`default_nettype none

module g2ld_month_walk
    import g2ld_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [COUNT_W-1:0] start_count,
    output walk_status_t            status
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [3:0]         pos_reg, pos_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   res_idx_reg, res_idx_next;
    logic [3:0]         res_month_reg, res_month_next;
    logic [4:0]         res_day_reg, res_day_next;
    logic               res_leap_reg, res_leap_next;

    logic [ENTRY_W-1:0] entry;
    logic [15:0]        month_bits;
    logic               long_year;
    logic [3:0]         last_bit;
    logic [3:0]         bit_pos;
    logic [4:0]         month_len;
    logic               fits;
    logic [3:0]         lmon;
    logic [4:0]         leap_after;

    always_comb
    begin
        entry      = rom_entry(ROM_IDX_W'(idx_reg));
        month_bits = entry[15:0];
        long_year  = entry >= ENTRY_W'(LONG_MIN);
        last_bit   = long_year ? 4'(LAST_BIT_LONG) : 4'(LAST_BIT_STD);
        // Months run from the highest flag bit down to bit 0.
        bit_pos    = last_bit - pos_reg;
        month_len  = 5'(SHORT_MONTH) + {4'b0, month_bits[bit_pos]};
        fits       = count_reg <= COUNT_W'(month_len);
        lmon       = pos_reg + 4'd1;
        leap_after = {1'b0, entry[19:16]} + 5'd1;
    end

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        busy_next      = busy_reg;
        done_next      = 1'b0;
        found_next     = found_reg;
        res_idx_next   = res_idx_reg;
        res_month_next = res_month_reg;
        res_day_next   = res_day_reg;
        res_leap_next  = res_leap_reg;

        if (start)
        begin
            count_next = start_count;
            idx_next   = '0;
            pos_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                busy_next     = 1'b0;
                done_next     = 1'b1;
                found_next    = 1'b1;
                res_idx_next  = idx_reg;
                res_day_next  = count_reg[4:0];
                res_leap_next = 1'b0;
                // In a year with a leap month, the leap month and the months after it shift down by one.
                if (long_year && {1'b0, lmon} == leap_after)
                begin
                    res_month_next = lmon - 4'd1;
                    res_leap_next  = 1'b1;
                end
                else if (long_year && {1'b0, lmon} > leap_after)
                begin
                    res_month_next = lmon - 4'd1;
                end
                else
                begin
                    res_month_next = lmon;
                end
            end
            else
            begin
                count_next = count_reg - COUNT_W'(month_len);
                if (pos_reg == last_bit)
                begin
                    if (idx_reg == IDX_W'(WALK_YEARS - 1))
                    begin
                        busy_next  = 1'b0;
                        done_next  = 1'b1;
                        found_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        pos_next = '0;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            res_idx_reg   <= '0;
            res_month_reg <= '0;
            res_day_reg   <= '0;
            res_leap_reg  <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            busy_reg      <= busy_next;
            done_reg      <= done_next;
            found_reg     <= found_next;
            res_idx_reg   <= res_idx_next;
            res_month_reg <= res_month_next;
            res_day_reg   <= res_day_next;
            res_leap_reg  <= res_leap_next;
        end
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign status.found    = found_reg;
    assign status.year_idx = res_idx_reg;
    assign status.month    = res_month_reg;
    assign status.day      = res_day_reg;
    assign status.leap     = res_leap_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("walk reports done while still busy");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("walk started while a walk is in progress");

    a_count_positive: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> count_reg != '0)
        else $error("remaining day count reached zero during the walk");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> (res_day_reg != 5'd0 && res_day_reg <= 5'd30))
        else $error("lunar day out of range");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |-> (res_month_reg != 4'd0 && res_month_reg <= 4'd12))
        else $error("lunar month out of range");

endmodule

`default_nettype wire

@@ dv/lunar_date_check.sv @@
`timescale 1ns / 100ps

module lunar_date_check
    import g2ld_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    // gregorian_year[11:0], gregorian_month[15:12], gregorian_day[20:16], zero fill
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // lunar_year[10:0], lunar_month[14:11], lunar_day[19:15], leap_month[20], zero fill
    input  wire logic [23:0] m_axis_tdata,
    // date_ok[0]
    input  wire logic        m_axis_tuser,
    output int               fail_count,
    output int               pending_count
);

    typedef struct packed {
        logic        date_ok;
        logic [10:0] lunar_year;
        logic [3:0]  lunar_month;
        logic [4:0]  lunar_day;
        logic        leap_month;
    } lunar_date_t;

    lunar_date_t expected_dates[$];
    int          errors;

    function automatic lunar_date_t lunar_from_gregorian(input logic [11:0] year,
                                                         input logic [3:0]  month,
                                                         input logic [4:0]  day);
        lunar_date_t        res;
        int                 yoff;
        int                 count;
        int                 idx;
        int                 last_bit;
        int                 pos;
        int                 len;
        int                 mon;
        int                 after;
        bit                 found;
        logic [ENTRY_W-1:0] entry;
        res      = '0;
        found    = 1'b0;
        idx      = 0;
        pos      = 0;
        last_bit = 0;
        entry    = '0;
        if (int'(year) < BASE_YEAR || month < 4'd1 || month > 4'd12)
        begin
            return res;
        end
        yoff  = int'(year) - BASE_YEAR;
        count = yoff * DAYS_PER_YEAR + yoff / 4 + int'(day)
              + int'(MONTH_OFFSET[int'(month) - 1]) - START_OFFSET;
        if (year[1:0] == 2'b00 && month > 4'd2)
        begin
            count++;
        end
        if (count < 1)
        begin
            return res;
        end
        // Peel off whole lunar months until the remaining count fits in one.
        while (!found && idx < WALK_YEARS)
        begin
            entry    = LUNAR_ROM[idx];
            last_bit = (entry < LONG_MIN) ? LAST_BIT_STD : LAST_BIT_LONG;
            pos      = last_bit;
            while (!found && pos >= 0)
            begin
                len = SHORT_MONTH + int'(entry[pos]);
                if (count <= len)
                begin
                    found = 1'b1;
                end
                else
                begin
                    count -= len;
                    pos--;
                end
            end
            if (!found)
            begin
                idx++;
            end
        end
        if (!found)
        begin
            return res;
        end
        mon = last_bit - pos + 1;
        // A thirteen-month year renumbers its leap month and the months after it.
        if (last_bit == LAST_BIT_LONG)
        begin
            after = int'(entry >> 16) + 1;
            if (mon == after)
            begin
                mon--;
                res.leap_month = 1'b1;
            end
            else if (mon > after)
            begin
                mon--;
            end
        end
        res.date_ok     = 1'b1;
        res.lunar_year  = 11'(BASE_YEAR + idx);
        res.lunar_month = 4'(mon);
        res.lunar_day   = 5'(count);
        return res;
    endfunction

    task automatic compare_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            errors++;
        end
    endtask

    initial
    begin
        errors = 0;
    end

    always @(posedge clk)
    begin
        lunar_date_t exp_date;
        lunar_date_t act_date;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                act_date.date_ok     = m_axis_tuser;
                act_date.lunar_year  = m_axis_tdata[10:0];
                act_date.lunar_month = m_axis_tdata[14:11];
                act_date.lunar_day   = m_axis_tdata[19:15];
                act_date.leap_month  = m_axis_tdata[20];
                if (expected_dates.size() == 0)
                begin
                    $error("Unexpected result with no request outstanding");
                    errors++;
                end
                else
                begin
                    exp_date = expected_dates.pop_front();
                    compare_field("date_ok", exp_date.date_ok, act_date.date_ok);
                    compare_field("lunar_year", exp_date.lunar_year, act_date.lunar_year);
                    compare_field("lunar_month", exp_date.lunar_month, act_date.lunar_month);
                    compare_field("lunar_day", exp_date.lunar_day, act_date.lunar_day);
                    compare_field("leap_month", exp_date.leap_month, act_date.leap_month);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_dates.push_back(lunar_from_gregorian(s_axis_tdata[11:0],
                                                              s_axis_tdata[15:12],
                                                              s_axis_tdata[20:16]));
            end
        end
        fail_count    <= errors;
        pending_count <= expected_dates.size();
    end

endmodule

@@ dv/gregorian_to_lunar_date_tb.sv @@
`timescale 1ns / 100ps

module gregorian_to_lunar_date_tb;

    localparam int RANDOM_REQUESTS = 440;
    localparam int QUIET_REQUESTS  = 120;
    localparam int HOLD_AT_REQUEST = 200;
    localparam int HOLD_CYCLES     = 4000;
    localparam int IDLE_PERCENT    = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          fail_count;
    int          pending_count;

    bit          idle_on;
    int          hold_requests;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    gregorian_to_lunar_date i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lunar_date_check i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_date(input logic [11:0] year, input logic [3:0] month,
                             input logic [4:0] day);
        if (idle_on)
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, day, month, year};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_random_date();
        int          pick;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            year  = 12'($urandom_range(2021, 1921));
            month = 4'($urandom_range(12, 1));
            day   = 5'($urandom_range(31, 1));
        end
        else if (pick < 93)
        begin
            year  = 12'($urandom_range(2100, 1900));
            month = 4'($urandom_range(12, 1));
            day   = 5'($urandom_range(31, 0));
        end
        else
        begin
            year  = 12'($urandom_range(4095, 0));
            month = 4'($urandom_range(15, 0));
            day   = 5'($urandom_range(31, 0));
        end
        send_date(year, month, day);
    endtask

    // Result side: random stalls while idle_on is set, plus one long hold-off when requested.
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left     = 0;
        holds_done    = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(99) < IDLE_PERCENT)
            begin
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idle_on       = 1'b1;
        hold_requests = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // First day of the table, the day before it and the first day of 1921.
        send_date(12'd1921, 4'd2, 5'd8);
        send_date(12'd1921, 4'd2, 5'd7);
        send_date(12'd1921, 4'd1, 5'd1);
        // Years below the table, including the field minimum.
        send_date(12'd1900, 4'd6, 5'd15);
        send_date(12'd1920, 4'd12, 5'd31);
        send_date(12'd0, 4'd0, 5'd0);
        // Month codes outside one to twelve.
        send_date(12'd1950, 4'd0, 5'd10);
        send_date(12'd1950, 4'd13, 5'd10);
        send_date(12'd1950, 4'd15, 5'd31);
        // Days that roll into the neighboring month.
        send_date(12'd1950, 4'd3, 5'd0);
        send_date(12'd1960, 4'd2, 5'd31);
        send_date(12'd1961, 4'd4, 5'd31);
        // Leap-year handling around February.
        send_date(12'd1924, 4'd3, 5'd1);
        send_date(12'd2000, 4'd2, 5'd29);
        send_date(12'd2000, 4'd3, 5'd1);
        // Dates inside and after intercalary months.
        send_date(12'd1922, 4'd6, 5'd30);
        send_date(12'd1922, 4'd7, 5'd20);
        send_date(12'd1925, 4'd6, 5'd10);
        send_date(12'd2020, 4'd6, 5'd1);
        send_date(12'd2020, 4'd12, 5'd31);
        // End of the table and beyond, up to the field maximum.
        send_date(12'd2021, 4'd2, 5'd10);
        send_date(12'd2021, 4'd2, 5'd11);
        send_date(12'd2100, 4'd12, 5'd31);
        send_date(12'd4095, 4'd15, 5'd31);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            idle_on = (n >= QUIET_REQUESTS);
            if (n == HOLD_AT_REQUEST)
            begin
                hold_requests++;
            end
            send_random_date();
        end
        s_axis_tvalid <= 1'b0;

        wait (pending_count == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/g2ld_pkg.sv
rtl/g2ld_month_walk.sv
rtl/gregorian_to_lunar_date.sv
dv/lunar_date_check.sv
dv/gregorian_to_lunar_date_tb.sv
